// ===== rtl/vrfc_pkg.sv =====
// Shared types and constants for the volume reply frame checker.
`timescale 1ns / 1ps

package vrfc_pkg;

  // Default saturation point of the message byte count.
  localparam int MAX_MESSAGE_BYTES = 4096;

  // Depth of the job queue between the front and back parts.
  localparam int QUEUE_DEPTH = 4;

  // Fixed message layout, in byte offsets.
  localparam int RC_OFS  = 32;
  localparam int CAT_OFS = 48;

  localparam logic [31:0] ID_RESET     = 32'd1138;
  localparam logic [7:0]  MAXLEN_RESET = 8'd128;

  localparam logic [7:0]  CHAR_LOW  = 8'h20;
  localparam logic [7:0]  CHAR_HIGH = 8'h7e;

  localparam logic [31:0] FLOAT_NEG_ZERO = 32'h8000_0000;
  localparam logic [31:0] FLOAT_ONE      = 32'h3f80_0000;

  // Register indexes on the configuration port.
  typedef enum logic {
    REG_EXPECTED_ID = 1'b0,
    REG_MAX_LENGTH  = 1'b1
  } reg_index_t;

  // Which header word a group of four bytes from offset 32 fills.
  typedef enum logic [1:0] {
    WORD_RC      = 2'd0,
    WORD_VOLUME  = 2'd1,
    WORD_PRESENT = 2'd2,
    WORD_LENGTH  = 2'd3
  } word_sel_t;

  typedef enum logic [2:0] {
    REASON_OK        = 3'd0,
    REASON_ID        = 3'd1,
    REASON_SHORT     = 3'd2,
    REASON_RC        = 3'd3,
    REASON_ABSENT    = 3'd4,
    REASON_LENGTH    = 3'd5,
    REASON_VOLUME    = 3'd6,
    REASON_CHARACTER = 3'd7
  } reason_t;

  // Work for the back part caused by one accepted item.
  typedef struct packed {
    logic        has_char;
    logic [7:0]  ch;
    logic        has_verdict;
    logic        ok;
    reason_t     reason;
    logic [31:0] volume;
    logic [7:0]  length;
  } job_t;

endpackage

// ===== rtl/vrfc_regs.sv =====
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps

module vrfc_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [31:0] expected_reply_id,
  output logic [7:0]  max_category_length
);

  vrfc_pkg::reg_index_t index;
  logic                 write_en;

  assign index    = vrfc_pkg::reg_index_t'(paddr[2]);
  assign write_en = psel && penable && pwrite;
  assign pready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_reply_id   <= vrfc_pkg::ID_RESET;
      max_category_length <= vrfc_pkg::MAXLEN_RESET;
    end else if (write_en) begin
      unique case (index)
        vrfc_pkg::REG_EXPECTED_ID: expected_reply_id   <= pwdata;
        vrfc_pkg::REG_MAX_LENGTH:  max_category_length <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      vrfc_pkg::REG_EXPECTED_ID: prdata = expected_reply_id;
      vrfc_pkg::REG_MAX_LENGTH:  prdata = {24'd0, max_category_length};
      default:                   prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/vrfc_front.sv =====
// Front part: takes message bytes, tracks header fields and builds jobs.
`timescale 1ns / 1ps

module vrfc_front #(
  parameter int MAX_MESSAGE_BYTES = vrfc_pkg::MAX_MESSAGE_BYTES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          msg_byte,
  input  logic [31:0]         message_id,
  input  logic                last_byte,
  input  logic [31:0]         expected_reply_id,
  input  logic [7:0]          max_category_length,
  input  logic                queue_full,
  output logic                push,
  output vrfc_pkg::job_t      push_job
);

  localparam int PW = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam logic [PW-1:0] POS_MAX = PW'(MAX_MESSAGE_BYTES);
  localparam logic [PW-1:0] POS_RC  = PW'(vrfc_pkg::RC_OFS);
  localparam logic [PW-1:0] POS_CAT = PW'(vrfc_pkg::CAT_OFS);

  logic [PW-1:0] byte_position;
  logic          id_matches;
  logic [31:0]   word_assembly;
  logic          return_code_zero;
  logic          category_present;
  logic [31:0]   declared_length;
  logic [31:0]   volume_word;
  logic          bad_character_seen;

  logic [PW-1:0] byte_position_next;
  logic          id_matches_next;
  logic [31:0]   word_assembly_next;
  logic          return_code_zero_next;
  logic          category_present_next;
  logic [31:0]   declared_length_next;
  logic [31:0]   volume_word_next;
  logic          bad_character_seen_next;

  logic          live;
  logic          in_words;
  logic          in_category;
  logic          word_done;
  logic [PW-1:0] cat_index;
  logic          length_usable;
  logic          emit_char;
  logic          printable;
  logic [PW-1:0] room;
  logic          volume_good;
  logic          accept;
  vrfc_pkg::reason_t reason;

  assign accept   = in_valid && in_ready;
  assign in_ready = !queue_full;

  // Bytes past the saturation point change nothing but can still end a message.
  assign live        = byte_position < POS_MAX;
  assign in_words    = live && (byte_position >= POS_RC) && (byte_position < POS_CAT);
  assign in_category = live && (byte_position >= POS_CAT);
  assign word_done   = in_words && (byte_position[1:0] == 2'b11);
  assign cat_index   = byte_position - POS_CAT;

  always_comb begin
    id_matches_next       = id_matches;
    return_code_zero_next = return_code_zero;
    category_present_next = category_present;
    declared_length_next  = declared_length;
    volume_word_next      = volume_word;
    word_assembly_next    = in_words ? {msg_byte, word_assembly[31:8]} : word_assembly;
    if (live && (byte_position == '0)) begin
      id_matches_next = (message_id == expected_reply_id);
    end
    if (word_done) begin
      unique case (vrfc_pkg::word_sel_t'(byte_position[3:2]))
        vrfc_pkg::WORD_RC:      return_code_zero_next = (word_assembly_next == 32'd0);
        vrfc_pkg::WORD_VOLUME:  volume_word_next      = word_assembly_next;
        vrfc_pkg::WORD_PRESENT: category_present_next = (word_assembly_next != 32'd0);
        vrfc_pkg::WORD_LENGTH:  declared_length_next  = word_assembly_next;
        default: ;
      endcase
    end
  end

  assign length_usable = (declared_length_next != 32'd0) &&
                         (declared_length_next <= {24'd0, max_category_length});
  assign emit_char = in_category && (32'(cat_index) < declared_length_next) && length_usable;
  assign printable = (msg_byte >= vrfc_pkg::CHAR_LOW) && (msg_byte <= vrfc_pkg::CHAR_HIGH);
  assign bad_character_seen_next = bad_character_seen || (emit_char && !printable);
  assign byte_position_next = live ? byte_position + PW'(1) : byte_position;

  // Room for category bytes; only meaningful once the size passes the header.
  assign room = byte_position_next - POS_CAT;
  assign volume_good = (volume_word_next == vrfc_pkg::FLOAT_NEG_ZERO) ||
                       (!volume_word_next[31] && (volume_word_next <= vrfc_pkg::FLOAT_ONE));

  always_comb begin
    priority if (!id_matches_next) begin
      reason = vrfc_pkg::REASON_ID;
    end else if (byte_position_next < POS_CAT) begin
      reason = vrfc_pkg::REASON_SHORT;
    end else if (!return_code_zero_next) begin
      reason = vrfc_pkg::REASON_RC;
    end else if (!category_present_next) begin
      reason = vrfc_pkg::REASON_ABSENT;
    end else if (!length_usable || (declared_length_next > 32'(room))) begin
      reason = vrfc_pkg::REASON_LENGTH;
    end else if (!volume_good) begin
      reason = vrfc_pkg::REASON_VOLUME;
    end else if (bad_character_seen_next) begin
      reason = vrfc_pkg::REASON_CHARACTER;
    end else begin
      reason = vrfc_pkg::REASON_OK;
    end
  end

  always_comb begin
    push_job.has_char    = emit_char;
    push_job.ch          = msg_byte;
    push_job.has_verdict = last_byte;
    push_job.ok          = (reason == vrfc_pkg::REASON_OK);
    push_job.reason      = reason;
    push_job.volume      = volume_word_next;
    push_job.length      = (reason == vrfc_pkg::REASON_OK) ? declared_length_next[7:0] : 8'd0;
  end

  assign push = accept && (emit_char || last_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position      <= '0;
      id_matches         <= 1'b0;
      word_assembly      <= 32'd0;
      return_code_zero   <= 1'b0;
      category_present   <= 1'b0;
      declared_length    <= 32'd0;
      volume_word        <= 32'd0;
      bad_character_seen <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        byte_position      <= '0;
        id_matches         <= 1'b0;
        word_assembly      <= 32'd0;
        return_code_zero   <= 1'b0;
        category_present   <= 1'b0;
        declared_length    <= 32'd0;
        volume_word        <= 32'd0;
        bad_character_seen <= 1'b0;
      end else begin
        byte_position      <= byte_position_next;
        id_matches         <= id_matches_next;
        word_assembly      <= word_assembly_next;
        return_code_zero   <= return_code_zero_next;
        category_present   <= category_present_next;
        declared_length    <= declared_length_next;
        volume_word        <= volume_word_next;
        bad_character_seen <= bad_character_seen_next;
      end
    end
  end

endmodule

// ===== rtl/vrfc_queue.sv =====
// Short job queue between the front and back parts.
`timescale 1ns / 1ps

module vrfc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  vrfc_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output vrfc_pkg::job_t head
);

  localparam int DEPTH = vrfc_pkg::QUEUE_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  vrfc_pkg::job_t slots [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  assign full    = (count == FULL_COUNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// ===== rtl/vrfc_back.sv =====
// Back part: turns queued jobs into result items through an output register.
`timescale 1ns / 1ps

module vrfc_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           empty,
  input  vrfc_pkg::job_t head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           result_kind,
  output logic [7:0]     category_char,
  output logic           reply_ok,
  output logic [2:0]     fail_reason,
  output logic [31:0]    volume_bits,
  output logic [7:0]     category_length,
  output logic           end_of_run
);

  // Set once the character of a two-result job has gone out.
  logic char_done;
  logic take_char;
  logic load;

  assign take_char = head.has_char && !char_done;
  assign load      = !empty && (!out_valid || out_ready);
  assign pop       = load && (!take_char || !head.has_verdict);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      char_done <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        char_done <= take_char && head.has_verdict;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (take_char) begin
        result_kind     <= 1'b0;
        category_char   <= head.ch;
        reply_ok        <= 1'b0;
        fail_reason     <= vrfc_pkg::REASON_OK;
        volume_bits     <= 32'd0;
        category_length <= 8'd0;
        end_of_run      <= 1'b0;
      end else begin
        result_kind     <= 1'b1;
        category_char   <= 8'd0;
        reply_ok        <= head.ok;
        fail_reason     <= head.reason;
        volume_bits     <= head.volume;
        category_length <= head.length;
        end_of_run      <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/volume_reply_frame_checker.sv =====
// Top level of the volume reply frame checker.
//
//   channel   direction  handshake             payload
//   input     in         in_valid / in_ready   msg_byte, message_id, last_byte
//   result    out        out_valid / out_ready result_kind .. end_of_run
//   config    in         psel / penable        paddr, pwdata, pwrite, prdata
//
// One byte is accepted per cycle while the job queue has room; the front part
// classifies it in that cycle. Results leave the output register at one per
// cycle while out_ready is high; a final byte that also carries a category
// character yields two result items. Reset is synchronous. A stall on the result
// side fills the queue before it stops the input side.
`timescale 1ns / 1ps

module volume_reply_frame_checker #(
  parameter int MAX_MESSAGE_BYTES = vrfc_pkg::MAX_MESSAGE_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  msg_byte,
  input  logic [31:0] message_id,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [7:0]  category_char,
  output logic        reply_ok,
  output logic [2:0]  fail_reason,
  output logic [31:0] volume_bits,
  output logic [7:0]  category_length,
  output logic        end_of_run,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0]    expected_reply_id;
  logic [7:0]     max_category_length;
  logic           queue_full;
  logic           queue_empty;
  logic           push;
  logic           pop;
  vrfc_pkg::job_t push_job;
  vrfc_pkg::job_t head;

  vrfc_regs u_regs (
    .clk                 (clk),
    .rst                 (rst),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .expected_reply_id   (expected_reply_id),
    .max_category_length (max_category_length)
  );

  vrfc_front #(
    .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
  ) u_front (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .msg_byte            (msg_byte),
    .message_id          (message_id),
    .last_byte           (last_byte),
    .expected_reply_id   (expected_reply_id),
    .max_category_length (max_category_length),
    .queue_full          (queue_full),
    .push                (push),
    .push_job            (push_job)
  );

  vrfc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (queue_full),
    .pop      (pop),
    .empty    (queue_empty),
    .head     (head)
  );

  vrfc_back u_back (
    .clk             (clk),
    .rst             (rst),
    .empty           (queue_empty),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .result_kind     (result_kind),
    .category_char   (category_char),
    .reply_ok        (reply_ok),
    .fail_reason     (fail_reason),
    .volume_bits     (volume_bits),
    .category_length (category_length),
    .end_of_run      (end_of_run)
  );

endmodule

// ===== verif/tb_volume_reply_frame_checker.sv =====
// Testbench for the volume reply frame checker: table rows and random replies.
`timescale 1ns / 1ps

module tb_volume_reply_frame_checker;

  // A short saturation point keeps the long-message case cheap to reach; every
  // other reply stays below it.
  localparam int TB_MAX_BYTES = 180;

  typedef struct packed {
    logic              kind;
    logic [7:0]        ch;
    logic              ok;
    vrfc_pkg::reason_t reason;
    logic [31:0]       volume;
    logic [7:0]        length;
    logic              eor;
  } reply_result_t;

  typedef struct {
    logic          typed;
    reply_result_t verdict;
  } verdict_note_t;

  typedef struct packed {
    logic [7:0]  b;
    logic [31:0] id;
    logic        last;
  } byte_item_t;

  typedef struct {
    logic [31:0]       id;
    logic [31:0]       rc;
    logic [31:0]       vol;
    logic [31:0]       present;
    logic [31:0]       len;
    int                size;
    int                bad_idx;
    logic              typed;
    vrfc_pkg::reason_t reason;
  } reply_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  msg_byte = '0;
  logic [31:0] message_id = '0;
  logic        last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        result_kind;
  logic [7:0]  category_char;
  logic        reply_ok;
  logic [2:0]  fail_reason;
  logic [31:0] volume_bits;
  logic [7:0]  category_length;
  logic        end_of_run;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  volume_reply_frame_checker #(
    .MAX_MESSAGE_BYTES (TB_MAX_BYTES)
  ) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .msg_byte(msg_byte), .message_id(message_id), .last_byte(last_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_kind(result_kind), .category_char(category_char), .reply_ok(reply_ok),
    .fail_reason(fail_reason), .volume_bits(volume_bits),
    .category_length(category_length), .end_of_run(end_of_run),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_volume_reply_frame_checker failed");
    $finish;
  end

  // Shadow registers and the predictor's view of the message in progress.
  logic [31:0] cfg_id = vrfc_pkg::ID_RESET;
  logic [7:0]  cfg_maxlen = vrfc_pkg::MAXLEN_RESET;
  logic [15:0] rx_pos = '0;
  logic        rx_id_ok = 1'b0;
  logic        rx_rc_zero = 1'b0;
  logic        rx_present = 1'b0;
  logic        rx_bad = 1'b0;
  logic [31:0] rx_word = '0;
  logic [31:0] rx_len = '0;
  logic [31:0] rx_vol = '0;

  reply_result_t reply_q[$];
  verdict_note_t verdict_notes[$];
  byte_item_t    tx_q[$];

  int errors = 0;
  int sent_bytes = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_token = 0;
  int hold_seen = 0;
  int hold_left = 0;

  function automatic logic length_usable();
    return rx_len != 0 && rx_len <= {24'd0, cfg_maxlen};
  endfunction

  task automatic predict_reply_byte(input logic [7:0] b, input logic [31:0] id,
                                    input logic last);
    reply_result_t r;
    verdict_note_t note;
    vrfc_pkg::reason_t why;
    logic [15:0] idx;
    if (rx_pos < 16'(TB_MAX_BYTES)) begin
      if (rx_pos == 16'd0) rx_id_ok = (id == cfg_id);
      if (rx_pos >= 16'(vrfc_pkg::RC_OFS) && rx_pos < 16'(vrfc_pkg::CAT_OFS)) begin
        rx_word = {b, rx_word[31:8]};
        if (rx_pos[1:0] == 2'b11) begin
          case (vrfc_pkg::word_sel_t'(rx_pos[3:2]))
            vrfc_pkg::WORD_RC:      rx_rc_zero = (rx_word == 32'd0);
            vrfc_pkg::WORD_VOLUME:  rx_vol = rx_word;
            vrfc_pkg::WORD_PRESENT: rx_present = (rx_word != 32'd0);
            default:                rx_len = rx_word;
          endcase
        end
      end else if (rx_pos >= 16'(vrfc_pkg::CAT_OFS)) begin
        idx = rx_pos - 16'(vrfc_pkg::CAT_OFS);
        if ({16'd0, idx} < rx_len && length_usable()) begin
          if (b < vrfc_pkg::CHAR_LOW || b > vrfc_pkg::CHAR_HIGH) rx_bad = 1'b1;
          r = '0;
          r.ch = b;
          reply_q.insert(reply_q.size(), r);
        end
      end
      rx_pos = rx_pos + 16'd1;
    end
    if (last) begin
      if (!rx_id_ok) why = vrfc_pkg::REASON_ID;
      else if (rx_pos < 16'(vrfc_pkg::CAT_OFS)) why = vrfc_pkg::REASON_SHORT;
      else if (!rx_rc_zero) why = vrfc_pkg::REASON_RC;
      else if (!rx_present) why = vrfc_pkg::REASON_ABSENT;
      else if (!length_usable() || rx_len > {16'd0, rx_pos} - 32'(vrfc_pkg::CAT_OFS))
        why = vrfc_pkg::REASON_LENGTH;
      else if (!(rx_vol == vrfc_pkg::FLOAT_NEG_ZERO ||
                 (!rx_vol[31] && rx_vol <= vrfc_pkg::FLOAT_ONE)))
        why = vrfc_pkg::REASON_VOLUME;
      else if (rx_bad) why = vrfc_pkg::REASON_CHARACTER;
      else why = vrfc_pkg::REASON_OK;
      r = '0;
      r.kind = 1'b1;
      r.ok = (why == vrfc_pkg::REASON_OK);
      r.reason = why;
      r.volume = rx_vol;
      r.length = (why == vrfc_pkg::REASON_OK) ? rx_len[7:0] : 8'd0;
      r.eor = 1'b1;
      // Table rows may carry their verdict typed in; it then takes the place of the prediction.
      if (verdict_notes.size() != 0) begin
        note = verdict_notes.pop_front();
        if (note.typed) r = note.verdict;
      end
      reply_q.insert(reply_q.size(), r);
      rx_pos = '0;
      rx_id_ok = 1'b0;
      rx_word = '0;
      rx_rc_zero = 1'b0;
      rx_present = 1'b0;
      rx_len = '0;
      rx_vol = '0;
      rx_bad = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // Prediction comes first so that a result can never overtake its own item.
  always @(posedge clk) begin
    reply_result_t want;
    if (!rst) begin
      if (in_valid && in_ready) predict_reply_byte(msg_byte, message_id, last_byte);
      if (out_valid && out_ready) begin
        if (reply_q.size() == 0) begin
          $error("result item arrived with nothing expected");
          errors++;
        end else begin
          want = reply_q.pop_front();
          check_field("result_kind", 32'(want.kind), 32'(result_kind));
          check_field("category_char", 32'(want.ch), 32'(category_char));
          check_field("reply_ok", 32'(want.ok), 32'(reply_ok));
          check_field("fail_reason", 32'(want.reason), 32'(fail_reason));
          check_field("volume_bits", want.volume, volume_bits);
          check_field("category_length", 32'(want.length), 32'(category_length));
          check_field("end_of_run", 32'(want.eor), 32'(end_of_run));
        end
      end
    end
  end

  always @(posedge clk) begin
    logic taken;
    taken = in_valid && in_ready;
    if (taken) void'(tx_q.pop_front());
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || taken) begin
      if (tx_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        msg_byte <= tx_q[0].b;
        message_id <= tx_q[0].id;
        last_byte <= tx_q[0].last;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = 300;
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic set_idle(input int mode);
    case (mode)
      1: begin send_idle_pct = 80; recv_idle_pct = 0; end
      2: begin send_idle_pct = 0; recv_idle_pct = 80; end
      3: begin send_idle_pct = 9; recv_idle_pct = 9; end
      default: begin send_idle_pct = 0; recv_idle_pct = 0; end
    endcase
  endtask

  task automatic write_reg(input vrfc_pkg::reg_index_t which, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {which, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    case (which)
      vrfc_pkg::REG_EXPECTED_ID: cfg_id = value;
      default:                   cfg_maxlen = value[7:0];
    endcase
  endtask

  task automatic drain();
    while (tx_q.size() != 0 || in_valid) @(posedge clk);
    while (reply_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Turns one reply description into its byte items, header words little-endian.
  task automatic queue_reply(input reply_row_t row);
    verdict_note_t note;
    byte_item_t it;
    logic [31:0] word;
    note.typed = row.typed;
    note.verdict = '0;
    note.verdict.kind = 1'b1;
    note.verdict.ok = (row.reason == vrfc_pkg::REASON_OK);
    note.verdict.reason = row.reason;
    note.verdict.volume = (row.size >= 40) ? row.vol : 32'd0;
    note.verdict.length = (row.reason == vrfc_pkg::REASON_OK) ? row.len[7:0] : 8'd0;
    note.verdict.eor = 1'b1;
    while (tx_q.size() > 8) @(posedge clk);
    verdict_notes.insert(verdict_notes.size(), note);
    for (int pos = 0; pos < row.size; pos++) begin
      it.id = (pos == 0) ? row.id : $urandom;
      it.last = (pos == row.size - 1);
      if (pos < vrfc_pkg::RC_OFS) begin
        it.b = 8'($urandom);
      end else if (pos < vrfc_pkg::CAT_OFS) begin
        case (vrfc_pkg::word_sel_t'((pos - vrfc_pkg::RC_OFS) / 4))
          vrfc_pkg::WORD_RC:      word = row.rc;
          vrfc_pkg::WORD_VOLUME:  word = row.vol;
          vrfc_pkg::WORD_PRESENT: word = row.present;
          default:                word = row.len;
        endcase
        it.b = 8'(word >> (8 * (pos % 4)));
      end else if (pos - vrfc_pkg::CAT_OFS == row.bad_idx) begin
        it.b = 8'($urandom_range(1) ? $urandom_range(8'h1f) : $urandom_range(8'hff, 8'h7f));
      end else if (pos - vrfc_pkg::CAT_OFS < row.len) begin
        it.b = 8'($urandom_range(vrfc_pkg::CHAR_HIGH, vrfc_pkg::CHAR_LOW));
      end else begin
        it.b = 8'($urandom);
      end
      tx_q.insert(tx_q.size(), it);
      sent_bytes++;
    end
  endtask

  // Mostly well-formed replies, with each field broken now and then.
  function automatic reply_row_t random_row();
    reply_row_t r;
    int lim;
    int lim_long;
    int n;
    lim = (cfg_maxlen == 0) ? 8 : int'(cfg_maxlen);
    lim_long = (lim < 64) ? lim : 64;
    r.typed = 1'b0;
    r.reason = vrfc_pkg::REASON_OK;
    r.id = ($urandom_range(9) == 0) ? $urandom : cfg_id;
    case ($urandom_range(15))
      0: r.rc = $urandom;
      1: r.rc = 32'd1 << $urandom_range(31);
      default: r.rc = '0;
    endcase
    case ($urandom_range(15))
      0: r.present = '0;
      1: r.present = $urandom;
      2: r.present = 32'd1 << $urandom_range(31);
      default: r.present = 32'd1;
    endcase
    case ($urandom_range(15))
      0: r.vol = vrfc_pkg::FLOAT_NEG_ZERO;
      1: r.vol = vrfc_pkg::FLOAT_ONE;
      2: r.vol = vrfc_pkg::FLOAT_ONE + 32'd1;
      3: r.vol = 32'h7f80_0000;
      4: r.vol = 32'h7fc0_0001;
      5: r.vol = vrfc_pkg::FLOAT_NEG_ZERO | $urandom;
      6: r.vol = $urandom;
      7: r.vol = '0;
      default: r.vol = $urandom_range(vrfc_pkg::FLOAT_ONE);
    endcase
    n = ($urandom_range(7) == 0) ? int'($urandom_range(lim_long, 1))
                                 : int'($urandom_range((lim < 12) ? lim : 12, 1));
    case ($urandom_range(19))
      0: r.len = '0;
      1: r.len = 32'(lim + 1);
      2: r.len = $urandom;
      default: r.len = 32'(n);
    endcase
    case ($urandom_range(19))
      0: r.size = int'($urandom_range(47, 1));
      1: r.size = vrfc_pkg::CAT_OFS + n - 1;
      default: r.size = vrfc_pkg::CAT_OFS + n + int'($urandom_range(3));
    endcase
    r.bad_idx = ($urandom_range(9) == 0) ? int'($urandom_range(n + 2)) : -1;
    return r;
  endfunction

  initial begin
    reply_row_t dir_rows[$];
    reply_row_t row;
    int start;
    int msg_no;
    msg_no = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    dir_rows = '{
      '{vrfc_pkg::ID_RESET, 0, vrfc_pkg::FLOAT_ONE, 1, 5, 53, -1, 1'b1, vrfc_pkg::REASON_OK},
      '{vrfc_pkg::ID_RESET - 1, 0, 0, 1, 5, 1, -1, 1'b1, vrfc_pkg::REASON_ID},
      '{vrfc_pkg::ID_RESET, 0, 0, 1, 5, 1, -1, 1'b1, vrfc_pkg::REASON_SHORT},
      '{vrfc_pkg::ID_RESET, 0, 32'h3f00_0000, 1, 5, 47, -1, 1'b1, vrfc_pkg::REASON_SHORT},
      '{vrfc_pkg::ID_RESET, 32'h8000_0000, 0, 1, 5, 48, -1, 1'b1, vrfc_pkg::REASON_RC},
      '{vrfc_pkg::ID_RESET, 0, 0, 0, 5, 48, -1, 1'b1, vrfc_pkg::REASON_ABSENT},
      '{vrfc_pkg::ID_RESET, 0, 0, 1, 0, 48, -1, 1'b1, vrfc_pkg::REASON_LENGTH},
      '{vrfc_pkg::ID_RESET, 0, 0, 1, 129, 48, -1, 1'b1, vrfc_pkg::REASON_LENGTH},
      '{vrfc_pkg::ID_RESET, 0, 0, 1, 10, 57, -1, 1'b1, vrfc_pkg::REASON_LENGTH},
      '{vrfc_pkg::ID_RESET, 0, vrfc_pkg::FLOAT_ONE + 1, 1, 3, 51, -1, 1'b1,
        vrfc_pkg::REASON_VOLUME},
      '{vrfc_pkg::ID_RESET, 0, vrfc_pkg::FLOAT_NEG_ZERO, 1, 3, 51, -1, 1'b1,
        vrfc_pkg::REASON_OK},
      '{vrfc_pkg::ID_RESET, 0, 32'h8000_0001, 1, 3, 51, -1, 1'b1, vrfc_pkg::REASON_VOLUME},
      '{vrfc_pkg::ID_RESET, 0, 32'h7fc0_0000, 1, 3, 51, -1, 1'b1, vrfc_pkg::REASON_VOLUME},
      '{vrfc_pkg::ID_RESET, 0, 32'h3e80_0000, 1, 6, 54, 2, 1'b1, vrfc_pkg::REASON_CHARACTER},
      '{vrfc_pkg::ID_RESET, 0, 0, 32'hffff_ffff, 128, 176, -1, 1'b1, vrfc_pkg::REASON_OK},
      '{vrfc_pkg::ID_RESET, 0, 0, 1, 32'hffff_ffff, 48, -1, 1'b1, vrfc_pkg::REASON_LENGTH},
      '{vrfc_pkg::ID_RESET, 0, 32'h3f7f_ffff, 1, 4, 60, 8, 1'b1, vrfc_pkg::REASON_OK},
      '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1, 1, 49, 0, 1'b0, vrfc_pkg::REASON_OK}
    };
    foreach (dir_rows[i]) begin
      set_idle(i % 4);
      queue_reply(dir_rows[i]);
    end
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        1: begin
          write_reg(vrfc_pkg::REG_EXPECTED_ID, 32'd0);
          write_reg(vrfc_pkg::REG_MAX_LENGTH, 32'd1);
        end
        2: begin
          write_reg(vrfc_pkg::REG_EXPECTED_ID, 32'hffff_ffff);
          write_reg(vrfc_pkg::REG_MAX_LENGTH, 32'd128);
        end
        3: write_reg(vrfc_pkg::REG_MAX_LENGTH, 32'd0);
        4: begin
          write_reg(vrfc_pkg::REG_EXPECTED_ID, $urandom);
          write_reg(vrfc_pkg::REG_MAX_LENGTH, 32'd255);
        end
        5: begin
          write_reg(vrfc_pkg::REG_EXPECTED_ID, vrfc_pkg::ID_RESET);
          write_reg(vrfc_pkg::REG_MAX_LENGTH, $urandom_range(128, 1));
        end
        default: ;
      endcase
      if (phase == 0) begin
        // The receiver holds off while a long reply streams in, so the queue fills.
        set_idle(0);
        hold_token <= hold_token + 1;
        queue_reply('{cfg_id, 0, vrfc_pkg::FLOAT_ONE, 1, 12, 60, -1, 1'b0,
                      vrfc_pkg::REASON_OK});
      end
      if (phase == 5) begin
        // Runs past the saturation point of the byte count.
        set_idle(msg_no % 4);
        queue_reply('{cfg_id, 0, 32'h3f00_0000, 1, 1, TB_MAX_BYTES + 4, -1, 1'b0,
                      vrfc_pkg::REASON_OK});
      end
      start = sent_bytes;
      while (sent_bytes - start < 30) begin
        row = random_row();
        set_idle((msg_no / 3) % 4);
        queue_reply(row);
        msg_no++;
      end
      drain();
    end

    if (reply_q.size() != 0) begin
      $error("%0d expected result items never arrived", reply_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb_volume_reply_frame_checker passed");
    end else begin
      $display("tb_volume_reply_frame_checker failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/vrfc_pkg.sv
rtl/vrfc_regs.sv
rtl/vrfc_front.sv
rtl/vrfc_queue.sv
rtl/vrfc_back.sv
rtl/volume_reply_frame_checker.sv
verif/tb_volume_reply_frame_checker.sv
